>>> hw/rtl/cau_pkg.sv
package cau_pkg;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_EQ  = 3'd4,
        KIND_MOD = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_SAT      = 2'd2
    } status_t;

endpackage

>>> hw/rtl/complex_arithmetic_unit_core.sv
// Throughput: one transaction per cycle unless a result waits on m_tready; four front stages form
// products, sums and magnitudes, then a row of WORD_BITS + 2 cells each resolves one quotient bit
// per divider and one root bit. The whole pipeline holds while a result waits on m_tready.
// Reset clears the stage valid bits only; data registers are not reset.
module complex_arithmetic_unit_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    localparam int S_TDATA_W = ((4 * WORD_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,   // a_re, a_im, b_re, b_im, zero pad
    input  logic [cau_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,   // res_re, res_im, zero pad
    output logic [cau_pkg::STATUS_W:0]    m_tuser    // equal, status
);

    import cau_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int NW  = 2 * W;
    localparam int QB  = W + 2;
    localparam int N   = QB;
    localparam int MW  = NW + 1;
    localparam int DDW = NW + F + 1;
    localparam int HW  = DDW - QB;
    localparam int CW  = (HW > NW) ? HW : NW;
    localparam int RW  = QB + 2;
    localparam int SW  = 2 * QB;
    localparam int NV  = 4 + N;

    localparam logic [MW-1:0] LIM     = MW'(1) << (W - 1);
    localparam logic [W-1:0]  MAX_POS = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  MIN_NEG = {1'b1, {(W - 1){1'b0}}};

    typedef struct packed {
        kind_t        kind;
        logic         eq;
        logic         dz;
        logic         ovf_re;
        logic         ovf_im;
        logic         neg_re;
        logic         neg_im;
        logic         early_sat;
        logic [W-1:0] early_re;
        logic [W-1:0] early_im;
    } side_t;

    function automatic logic [W:0] pack_sat(input logic [MW-1:0] mag, input logic neg);
        logic [MW-1:0] negd;
        negd = ~mag + MW'(1);
        if (neg) begin
            if (mag > LIM) begin
                return {1'b1, MIN_NEG};
            end
            return {1'b0, negd[W-1:0]};
        end
        if (mag > (LIM - MW'(1))) begin
            return {1'b1, MAX_POS};
        end
        return {1'b0, mag[W-1:0]};
    endfunction

    logic adv;
    logic valid_reg [0:NV-1];

    logic signed [W-1:0] in_a_re, in_a_im, in_b_re, in_b_im;
    kind_t               in_kind;

    // Stage 1: products and add/subtract.
    kind_t                s1_kind_reg;
    logic                 s1_eq_reg;
    logic signed [W:0]    s1_as_re_reg, s1_as_im_reg, s1_as_re_next, s1_as_im_next;
    logic signed [NW-1:0] s1_rr_reg, s1_ii_reg, s1_ri_reg, s1_ir_reg;
    logic signed [NW-1:0] s1_bb_re_reg, s1_bb_im_reg, s1_aa_re_reg, s1_aa_im_reg;

    // Stage 2: numerators and squared magnitudes.
    kind_t                s2_kind_reg;
    logic                 s2_eq_reg;
    logic signed [W:0]    s2_as_re_reg, s2_as_im_reg;
    logic signed [NW:0]   s2_n_re_reg, s2_n_im_reg, s2_n_re_next, s2_n_im_next;
    logic [NW-1:0]        s2_den_reg, s2_sq_reg;

    // Stage 3: sign and magnitude.
    kind_t                s3_kind_reg;
    logic                 s3_eq_reg;
    logic                 s3_dz_reg;
    logic signed [W:0]    s3_as_re_reg, s3_as_im_reg;
    logic [NW:0]          s3_mag_re_next, s3_mag_im_next;
    logic [NW-1:0]        s3_mag_re_reg, s3_mag_im_reg;
    logic                 s3_neg_re_reg, s3_neg_im_reg;
    logic [NW-1:0]        s3_den_reg, s3_sq_reg;

    // Stage 4: product rounding.
    kind_t                s4_kind_reg;
    logic                 s4_eq_reg;
    logic                 s4_dz_reg;
    logic signed [W:0]    s4_as_re_reg, s4_as_im_reg;
    logic [NW-1:0]        s4_mag_re_reg, s4_mag_im_reg;
    logic                 s4_neg_re_reg, s4_neg_im_reg;
    logic [NW-1:0]        s4_den_reg, s4_sq_reg;
    logic [MW-1:0]        s4_mul_re_reg, s4_mul_im_reg;
    logic [MW:0]          s4_rnd_re, s4_rnd_im;

    // Cell row.
    side_t         side_first;
    side_t         side_reg [1:N];
    logic [DDW-1:0] dd_re, dd_im;
    logic [HW-1:0]  hi_re, hi_im;
    logic [MW-1:0]  as_mag_re, as_mag_im;
    logic [W:0]     pk_re, pk_im;

    logic [NW-1:0] dre_rem [0:N];
    logic [NW-1:0] dre_den [0:N];
    logic [QB-1:0] dre_dd  [0:N];
    logic [QB-1:0] dre_q   [0:N];
    logic [NW-1:0] dim_rem [0:N];
    logic [NW-1:0] dim_den [0:N];
    logic [QB-1:0] dim_dd  [0:N];
    logic [QB-1:0] dim_q   [0:N];
    logic [RW-1:0] sq_rem  [0:N];
    logic [QB-1:0] sq_root [0:N];
    logic [SW-1:0] sq_rad  [0:N];

    // Output stage.
    logic          m_tvalid_reg;
    logic [W-1:0]  res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic          equal_reg;
    status_t       status_reg, status_next;
    kind_t         out_kind_reg;
    logic [QB:0]   qr_re, qr_im;
    logic [MW-1:0] div_mag_re, div_mag_im, mod_mag;
    logic [QB-1:0] root_rnd;
    logic [W:0]    fr_re, fr_im;
    side_t         last;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    assign in_a_re = s_tdata[W-1:0];
    assign in_a_im = s_tdata[2*W-1:W];
    assign in_b_re = s_tdata[3*W-1:2*W];
    assign in_b_im = s_tdata[4*W-1:3*W];
    assign in_kind = kind_t'(s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NV; i++) begin
                valid_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg[0] <= s_tvalid;
            for (int i = 1; i < NV; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
            m_tvalid_reg <= valid_reg[NV-1];
        end
    end

    always_comb begin
        if (in_kind == KIND_SUB) begin
            s1_as_re_next = (W+1)'(in_a_re) - (W+1)'(in_b_re);
            s1_as_im_next = (W+1)'(in_a_im) - (W+1)'(in_b_im);
        end else begin
            s1_as_re_next = (W+1)'(in_a_re) + (W+1)'(in_b_re);
            s1_as_im_next = (W+1)'(in_a_im) + (W+1)'(in_b_im);
        end
    end

    always_comb begin
        if (s1_kind_reg == KIND_MUL) begin
            s2_n_re_next = (NW+1)'(s1_rr_reg) - (NW+1)'(s1_ii_reg);
            s2_n_im_next = (NW+1)'(s1_ri_reg) + (NW+1)'(s1_ir_reg);
        end else begin
            s2_n_re_next = (NW+1)'(s1_rr_reg) + (NW+1)'(s1_ii_reg);
            s2_n_im_next = (NW+1)'(s1_ir_reg) - (NW+1)'(s1_ri_reg);
        end
        s3_mag_re_next = s2_n_re_reg[NW] ? (NW+1)'(-s2_n_re_reg) : s2_n_re_reg;
        s3_mag_im_next = s2_n_im_reg[NW] ? (NW+1)'(-s2_n_im_reg) : s2_n_im_reg;
        s4_rnd_re = (MW+1)'((MW'(s3_mag_re_reg) << 1) >> F) + (MW+1)'(1);
        s4_rnd_im = (MW+1)'((MW'(s3_mag_im_reg) << 1) >> F) + (MW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_kind_reg  <= in_kind;
            s1_eq_reg    <= (in_a_re == in_b_re) && (in_a_im == in_b_im);
            s1_as_re_reg <= s1_as_re_next;
            s1_as_im_reg <= s1_as_im_next;
            s1_rr_reg    <= in_a_re * in_b_re;
            s1_ii_reg    <= in_a_im * in_b_im;
            s1_ri_reg    <= in_a_re * in_b_im;
            s1_ir_reg    <= in_a_im * in_b_re;
            s1_bb_re_reg <= in_b_re * in_b_re;
            s1_bb_im_reg <= in_b_im * in_b_im;
            s1_aa_re_reg <= in_a_re * in_a_re;
            s1_aa_im_reg <= in_a_im * in_a_im;

            s2_kind_reg  <= s1_kind_reg;
            s2_eq_reg    <= s1_eq_reg;
            s2_as_re_reg <= s1_as_re_reg;
            s2_as_im_reg <= s1_as_im_reg;
            s2_n_re_reg  <= s2_n_re_next;
            s2_n_im_reg  <= s2_n_im_next;
            s2_den_reg   <= $unsigned(s1_bb_re_reg) + $unsigned(s1_bb_im_reg);
            s2_sq_reg    <= $unsigned(s1_aa_re_reg) + $unsigned(s1_aa_im_reg);

            s3_kind_reg   <= s2_kind_reg;
            s3_eq_reg     <= s2_eq_reg;
            s3_dz_reg     <= (s2_den_reg == '0);
            s3_as_re_reg  <= s2_as_re_reg;
            s3_as_im_reg  <= s2_as_im_reg;
            s3_mag_re_reg <= s3_mag_re_next[NW-1:0];
            s3_mag_im_reg <= s3_mag_im_next[NW-1:0];
            s3_neg_re_reg <= s2_n_re_reg[NW];
            s3_neg_im_reg <= s2_n_im_reg[NW];
            s3_den_reg    <= s2_den_reg;
            s3_sq_reg     <= s2_sq_reg;

            s4_kind_reg   <= s3_kind_reg;
            s4_eq_reg     <= s3_eq_reg;
            s4_dz_reg     <= s3_dz_reg;
            s4_as_re_reg  <= s3_as_re_reg;
            s4_as_im_reg  <= s3_as_im_reg;
            s4_mag_re_reg <= s3_mag_re_reg;
            s4_mag_im_reg <= s3_mag_im_reg;
            s4_neg_re_reg <= s3_neg_re_reg;
            s4_neg_im_reg <= s3_neg_im_reg;
            s4_den_reg    <= s3_den_reg;
            s4_sq_reg     <= s3_sq_reg;
            s4_mul_re_reg <= s4_rnd_re[MW:1];
            s4_mul_im_reg <= s4_rnd_im[MW:1];
        end
    end

    always_comb begin
        dd_re = DDW'(s4_mag_re_reg) << (F + 1);
        dd_im = DDW'(s4_mag_im_reg) << (F + 1);
        hi_re = dd_re[DDW-1:QB];
        hi_im = dd_im[DDW-1:QB];

        as_mag_re = s4_as_re_reg[W] ? (~MW'(s4_as_re_reg) + MW'(1)) : MW'(s4_as_re_reg);
        as_mag_im = s4_as_im_reg[W] ? (~MW'(s4_as_im_reg) + MW'(1)) : MW'(s4_as_im_reg);

        unique case (s4_kind_reg)
            KIND_ADD, KIND_SUB: begin
                pk_re = pack_sat(as_mag_re, s4_as_re_reg[W]);
                pk_im = pack_sat(as_mag_im, s4_as_im_reg[W]);
            end
            KIND_MUL: begin
                pk_re = pack_sat(s4_mul_re_reg, s4_neg_re_reg);
                pk_im = pack_sat(s4_mul_im_reg, s4_neg_im_reg);
            end
            default: begin
                pk_re = '0;
                pk_im = '0;
            end
        endcase

        side_first.kind      = s4_kind_reg;
        side_first.eq        = s4_eq_reg;
        side_first.dz        = s4_dz_reg;
        side_first.ovf_re    = (CW'(hi_re) >= CW'(s4_den_reg));
        side_first.ovf_im    = (CW'(hi_im) >= CW'(s4_den_reg));
        side_first.neg_re    = s4_neg_re_reg;
        side_first.neg_im    = s4_neg_im_reg;
        side_first.early_sat = pk_re[W] | pk_im[W];
        side_first.early_re  = pk_re[W-1:0];
        side_first.early_im  = pk_im[W-1:0];

        dre_rem[0] = NW'(hi_re);
        dre_den[0] = s4_den_reg;
        dre_dd[0]  = dd_re[QB-1:0];
        dre_q[0]   = '0;
        dim_rem[0] = NW'(hi_im);
        dim_den[0] = s4_den_reg;
        dim_dd[0]  = dd_im[QB-1:0];
        dim_q[0]   = '0;
        sq_rem[0]  = '0;
        sq_root[0] = '0;
        sq_rad[0]  = SW'(s4_sq_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[1] <= side_first;
            for (int k = 2; k <= N; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        cau_div_cell #(
            .REM_W (NW),
            .Q_W   (QB)
        ) u_div_re (
            .aclk  (aclk),
            .en    (adv),
            .rem_i (dre_rem[g]),
            .den_i (dre_den[g]),
            .dd_i  (dre_dd[g]),
            .q_i   (dre_q[g]),
            .rem_o (dre_rem[g+1]),
            .den_o (dre_den[g+1]),
            .dd_o  (dre_dd[g+1]),
            .q_o   (dre_q[g+1])
        );

        cau_div_cell #(
            .REM_W (NW),
            .Q_W   (QB)
        ) u_div_im (
            .aclk  (aclk),
            .en    (adv),
            .rem_i (dim_rem[g]),
            .den_i (dim_den[g]),
            .dd_i  (dim_dd[g]),
            .q_i   (dim_q[g]),
            .rem_o (dim_rem[g+1]),
            .den_o (dim_den[g+1]),
            .dd_o  (dim_dd[g+1]),
            .q_o   (dim_q[g+1])
        );

        cau_sqrt_cell #(
            .ROOT_W (QB)
        ) u_sqrt (
            .aclk   (aclk),
            .en     (adv),
            .rem_i  (sq_rem[g]),
            .root_i (sq_root[g]),
            .rad_i  (sq_rad[g]),
            .rem_o  (sq_rem[g+1]),
            .root_o (sq_root[g+1]),
            .rad_o  (sq_rad[g+1])
        );
    end

    always_comb begin
        last  = side_reg[N];
        qr_re = (QB+1)'(dre_q[N]) + (QB+1)'(1);
        qr_im = (QB+1)'(dim_q[N]) + (QB+1)'(1);
        div_mag_re = last.ovf_re ? '1 : MW'(qr_re[QB:1]);
        div_mag_im = last.ovf_im ? '1 : MW'(qr_im[QB:1]);
        root_rnd = (RW'(sq_root[N]) < sq_rem[N]) ? (sq_root[N] + QB'(1)) : sq_root[N];
        mod_mag  = MW'(root_rnd);
        fr_re = '0;
        fr_im = '0;

        unique case (last.kind)
            KIND_DIV: begin
                fr_re = pack_sat(div_mag_re, last.neg_re);
                fr_im = pack_sat(div_mag_im, last.neg_im);
                if (last.dz) begin
                    res_re_next = '0;
                    res_im_next = '0;
                    status_next = STATUS_DIV_ZERO;
                end else begin
                    res_re_next = fr_re[W-1:0];
                    res_im_next = fr_im[W-1:0];
                    status_next = (fr_re[W] | fr_im[W]) ? STATUS_SAT : STATUS_OK;
                end
            end
            KIND_MOD: begin
                fr_re       = pack_sat(mod_mag, 1'b0);
                res_re_next = fr_re[W-1:0];
                res_im_next = '0;
                status_next = fr_re[W] ? STATUS_SAT : STATUS_OK;
            end
            default: begin
                res_re_next = last.early_re;
                res_im_next = last.early_im;
                status_next = last.early_sat ? STATUS_SAT : STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_re_reg   <= res_re_next;
            res_im_reg   <= res_im_next;
            equal_reg    <= last.eq;
            status_reg   <= status_next;
            out_kind_reg <= last.kind;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({res_im_reg, res_re_reg});
    assign m_tuser  = {status_reg, equal_reg};

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && status_reg == STATUS_DIV_ZERO) |->
            (res_re_reg == '0 && res_im_reg == '0 && out_kind_reg == KIND_DIV))
        else $error("division by zero transaction with nonzero result");

    a_mod_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_kind_reg == KIND_MOD) |->
            (!res_re_reg[W-1] && res_im_reg == '0))
        else $error("modulus result negative or with imaginary part");

    a_eq_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_kind_reg == KIND_EQ) |->
            (res_re_reg == '0 && res_im_reg == '0 && status_reg == STATUS_OK))
        else $error("equal test transaction with nonzero result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg)
        else $error("result valid right after reset");

endmodule

>>> hw/rtl/cau_div_cell.sv
module cau_div_cell #(
    parameter int REM_W = 64,
    parameter int Q_W   = 34
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [REM_W-1:0] rem_i,
    input  logic [REM_W-1:0] den_i,
    input  logic [Q_W-1:0]   dd_i,
    input  logic [Q_W-1:0]   q_i,
    output logic [REM_W-1:0] rem_o,
    output logic [REM_W-1:0] den_o,
    output logic [Q_W-1:0]   dd_o,
    output logic [Q_W-1:0]   q_o
);

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [REM_W-1:0] den_reg;
    logic [Q_W-1:0]   dd_reg, dd_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;

    always_comb begin
        trial    = {rem_i, dd_i[Q_W-1]};
        diff     = trial - {1'b0, den_i};
        ge       = (trial >= {1'b0, den_i});
        rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        q_next   = {q_i[Q_W-2:0], ge};
        dd_next  = {dd_i[Q_W-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= den_i;
            dd_reg  <= dd_next;
            q_reg   <= q_next;
        end
    end

    assign rem_o = rem_reg;
    assign den_o = den_reg;
    assign dd_o  = dd_reg;
    assign q_o   = q_reg;

endmodule

>>> hw/rtl/cau_sqrt_cell.sv
module cau_sqrt_cell #(
    parameter int ROOT_W = 34
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ROOT_W+1:0]     rem_i,
    input  logic [ROOT_W-1:0]     root_i,
    input  logic [2*ROOT_W-1:0]   rad_i,
    output logic [ROOT_W+1:0]     rem_o,
    output logic [ROOT_W-1:0]     root_o,
    output logic [2*ROOT_W-1:0]   rad_o
);

    localparam int REM_W = ROOT_W + 2;
    localparam int RAD_W = 2 * ROOT_W;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb begin
        cur       = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
        trial     = {root_i, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? (cur - trial) : cur;
        root_next = {root_i[ROOT_W-2:0], ge};
        rad_next  = {rad_i[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign rem_o  = rem_reg;
    assign root_o = root_reg;
    assign rad_o  = rad_reg;

endmodule
